@@ hdl/kcl_pkg.sv @@
// ----------------------------------------------------------------------------
// kcl_pkg
// Shared constants and types for the keypad code lock: code length, request
// and verdict codes, and the command/status bundles between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package kcl_pkg;

  // Number of keys in one code
  localparam int unsigned CODE_LEN = 4;
  // Width of an index into the key buffers
  localparam int unsigned IDX_W = (CODE_LEN > 1) ? $clog2(CODE_LEN) : 1;

  localparam int unsigned KEY_W     = 8;
  localparam int unsigned TIMEOUT_W = 16;
  localparam int unsigned REQ_W     = 2;
  localparam int unsigned VERDICT_W = 2;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd6000;

  // Request types
  localparam logic [REQ_W-1:0] REQ_KEY    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_TICK   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FORGET = 2'd2;

  // Verdicts
  localparam logic [VERDICT_W-1:0] VERDICT_NOTHING = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_CHANGED = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_WRONG   = 2'd2;
  localparam logic [VERDICT_W-1:0] VERDICT_SUCCESS = 2'd3;

  // Controller to datapath
  typedef struct packed {
    logic take;       // input transfer happens this cycle
    logic scan_step;  // process one key position of the code scan
  } kcl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic entry_done; // current key press completes the entry
    logic scan_last;  // scan is at the last key position
  } kcl_sts_t;

endpackage

@@ hdl/keypad_code_lock.sv @@
// ----------------------------------------------------------------------------
// keypad_code_lock
// Keypad code lock with enrollment: collects key presses into an entry,
// enrolls or checks it against the stored code, and times out idle entries.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries req_type_i and key_code_i:
//   a key press, one timer tick or a forget-code request. Every input transfer
//   yields exactly one verdict on the output channel (out_valid_o/out_ready_i).
//   The config channel (cfg_valid_i/cfg_ready_o/cfg_data_i) writes the
//   inactivity timeout in ticks; it is always ready and should be used while
//   the lock is idle.
//   Timing: ticks, forget requests and non-final keys give their verdict in the
//   cycle after the transfer. The key that completes the code starts a serial
//   scan over the key buffers, one key position per cycle, and its verdict is
//   registered at the end of that scan. Short requests are taken one item per
//   cycle while the output channel does not stall; no new item is taken while
//   a scan runs.
//   Reset: no code enrolled, no entry in progress, timeout 6000 ticks.
//   Stall: a single result register holds the verdict; a new item is taken
//   in the cycle that register is emptied, and none while it stays full.
// ----------------------------------------------------------------------------
module keypad_code_lock (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [kcl_pkg::REQ_W-1:0]         req_type_i,
  input  logic [kcl_pkg::KEY_W-1:0]         key_code_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [kcl_pkg::VERDICT_W-1:0]     verdict_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [kcl_pkg::TIMEOUT_W-1:0]     cfg_data_i
);

  kcl_pkg::kcl_cmd_t cmd;
  kcl_pkg::kcl_sts_t sts;

  // Config writes complete at once
  assign cfg_ready_o = 1'b1;

  kcl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  kcl_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .req_type_i (req_type_i),
    .key_code_i (key_code_i),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .verdict_o  (verdict_o)
  );

endmodule

@@ hdl/kcl_datapath.sv @@
// ----------------------------------------------------------------------------
// kcl_datapath
// Entry and stored key buffers, key counter, inactivity countdown, timeout
// register, serial compare/enroll scan and the registered verdict.
// ----------------------------------------------------------------------------
module kcl_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  kcl_pkg::kcl_cmd_t                   cmd_i,
  output kcl_pkg::kcl_sts_t                   sts_o,
  input  logic [kcl_pkg::REQ_W-1:0]           req_type_i,
  input  logic [kcl_pkg::KEY_W-1:0]           key_code_i,
  input  logic                                cfg_we_i,
  input  logic [kcl_pkg::TIMEOUT_W-1:0]       cfg_data_i,
  output logic [kcl_pkg::VERDICT_W-1:0]       verdict_o
);

  localparam logic [kcl_pkg::IDX_W-1:0] LAST_IDX = kcl_pkg::IDX_W'(kcl_pkg::CODE_LEN - 1);

  logic [kcl_pkg::TIMEOUT_W-1:0] timeout_q;
  logic [kcl_pkg::TIMEOUT_W-1:0] countdown_q, countdown_d;
  logic                          entering_q, entering_d;
  logic [kcl_pkg::IDX_W-1:0]     key_cnt_q, key_cnt_d;
  logic                          enrolled_q, enrolled_d;
  logic [kcl_pkg::IDX_W-1:0]     scan_idx_q, scan_idx_d;
  logic                          enroll_q, enroll_d;
  logic                          match_q, match_d;

  logic [kcl_pkg::KEY_W-1:0]     entry_keys_q  [kcl_pkg::CODE_LEN];
  logic [kcl_pkg::KEY_W-1:0]     stored_keys_q [kcl_pkg::CODE_LEN];
  logic [kcl_pkg::VERDICT_W-1:0] verdict_q;

  logic [kcl_pkg::IDX_W-1:0]     press_idx;
  logic                          is_key;
  logic                          key_eq;
  logic [kcl_pkg::VERDICT_W-1:0] imm_verdict;
  logic [kcl_pkg::VERDICT_W-1:0] scan_verdict;
  logic                          load_imm;
  logic                          load_scan;

  // Decode the current request
  assign is_key    = (req_type_i == kcl_pkg::REQ_KEY);
  assign press_idx = entering_q ? key_cnt_q : '0;
  assign key_eq    = (stored_keys_q[scan_idx_q] == entry_keys_q[scan_idx_q]);

  assign sts_o.entry_done = is_key && (press_idx == LAST_IDX);
  assign sts_o.scan_last  = (scan_idx_q == LAST_IDX);

  assign load_imm  = cmd_i.take && !sts_o.entry_done;
  assign load_scan = cmd_i.scan_step && sts_o.scan_last;

  // Verdict of a request that finishes in the transfer cycle
  always_comb begin
    case (req_type_i)
      kcl_pkg::REQ_TICK: begin
        imm_verdict = (entering_q && (countdown_q == '0)) ? kcl_pkg::VERDICT_WRONG
                                                          : kcl_pkg::VERDICT_NOTHING;
      end
      default: begin
        imm_verdict = kcl_pkg::VERDICT_NOTHING;
      end
    endcase
  end

  // Verdict at the end of the scan
  assign scan_verdict = enroll_q ? kcl_pkg::VERDICT_CHANGED :
                        (match_q && key_eq) ? kcl_pkg::VERDICT_SUCCESS :
                        kcl_pkg::VERDICT_WRONG;

  // Next state of the lock
  always_comb begin
    entering_d  = entering_q;
    key_cnt_d   = key_cnt_q;
    countdown_d = countdown_q;
    enrolled_d  = enrolled_q;
    scan_idx_d  = scan_idx_q;
    enroll_d    = enroll_q;
    match_d     = match_q;
    if (cmd_i.take) begin
      case (req_type_i)
        kcl_pkg::REQ_KEY: begin
          countdown_d = timeout_q;
          if (sts_o.entry_done) begin
            // entry complete: drop to idle and start the scan
            entering_d = 1'b0;
            key_cnt_d  = '0;
            scan_idx_d = '0;
            match_d    = 1'b1;
            enroll_d   = !enrolled_q;
          end else begin
            entering_d = 1'b1;
            key_cnt_d  = press_idx + 1'b1;
          end
        end
        kcl_pkg::REQ_TICK: begin
          if (entering_q) begin
            if (countdown_q == '0) begin
              entering_d = 1'b0;
              key_cnt_d  = '0;
            end else begin
              countdown_d = countdown_q - 1'b1;
            end
          end
        end
        kcl_pkg::REQ_FORGET: begin
          enrolled_d = 1'b0;
        end
        default: begin
        end
      endcase
    end
    if (cmd_i.scan_step) begin
      match_d = match_q && key_eq;
      if (sts_o.scan_last) begin
        if (enroll_q) begin
          enrolled_d = 1'b1;
        end
      end else begin
        scan_idx_d = scan_idx_q + 1'b1;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q   <= kcl_pkg::TIMEOUT_RESET;
      countdown_q <= '0;
      entering_q  <= 1'b0;
      key_cnt_q   <= '0;
      enrolled_q  <= 1'b0;
      scan_idx_q  <= '0;
      enroll_q    <= 1'b0;
      match_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        timeout_q <= cfg_data_i;
      end
      countdown_q <= countdown_d;
      entering_q  <= entering_d;
      key_cnt_q   <= key_cnt_d;
      enrolled_q  <= enrolled_d;
      scan_idx_q  <= scan_idx_d;
      enroll_q    <= enroll_d;
      match_q     <= match_d;
    end
  end

  // Key buffers and verdict register
  always_ff @(posedge clk_i) begin
    if (cmd_i.take && is_key) begin
      entry_keys_q[press_idx] <= key_code_i;
    end
    if (cmd_i.scan_step && enroll_q) begin
      stored_keys_q[scan_idx_q] <= entry_keys_q[scan_idx_q];
    end
    if (load_imm) begin
      verdict_q <= imm_verdict;
    end else if (load_scan) begin
      verdict_q <= scan_verdict;
    end
  end

  assign verdict_o = verdict_q;

endmodule

@@ hdl/kcl_ctrl.sv @@
// ----------------------------------------------------------------------------
// kcl_ctrl
// Controller: input and output handshakes, scan sequencing and the valid bit
// of the result register.
// ----------------------------------------------------------------------------
module kcl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output kcl_pkg::kcl_cmd_t cmd_o,
  input  kcl_pkg::kcl_sts_t sts_i
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic load_result;

  // Accept only outside a scan and when the result register is free or being emptied
  assign in_ready_o      = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign cmd_o.take      = in_valid_i && in_ready_o;
  assign cmd_o.scan_step = (state_q == ST_SCAN);

  assign load_result = (cmd_o.take && !sts_i.entry_done) ||
                       (cmd_o.scan_step && sts_i.scan_last);

  // Advance the sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.take && sts_i.entry_done) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts_i.scan_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold the result until its transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_result) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // Result register stays empty while a scan runs
  a_scan_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> !out_valid_q)
    else $error("result pending during scan");

  // No input transfer during a scan
  a_scan_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> !cmd_o.take)
    else $error("input taken during scan");

  // Completed entry starts a scan
  a_entry_scans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.take && sts_i.entry_done) |=> (state_q == ST_SCAN))
    else $error("completed entry did not start scan");

  // End of scan presents a result
  a_scan_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.scan_step && sts_i.scan_last) |=> (out_valid_q && state_q == ST_IDLE))
    else $error("scan ended without result");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the keypad code lock. It drives key presses, ticks,
// forget requests and unused requests through the valid/ready input channel
// and checks every verdict against a cycle-free model of the lock. Timeout
// settings change between phases, and both channels stall at random.
// ----------------------------------------------------------------------------
module tb_top;

  // Request code that the lock ignores
  localparam logic [kcl_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned SETTLE_CYCLES = kcl_pkg::CODE_LEN + 4;
  localparam int unsigned PHASE_ITEMS = 155;
  localparam int unsigned NUM_PHASES = 6;

  // --------------------------------------------------------------------------
  // Lock model and expected verdict store
  // --------------------------------------------------------------------------
  class lock_scoreboard;
    logic [kcl_pkg::TIMEOUT_W-1:0] timeout_ticks;
    logic [kcl_pkg::TIMEOUT_W-1:0] countdown;
    bit                            entering;
    bit                            code_enrolled;
    int unsigned                   key_count;
    logic [kcl_pkg::KEY_W-1:0]     entry_keys [kcl_pkg::CODE_LEN];
    logic [kcl_pkg::KEY_W-1:0]     stored_keys [kcl_pkg::CODE_LEN];
    logic [kcl_pkg::VERDICT_W-1:0] expected_verdicts [$];
    int unsigned                   error_count;

    function new();
      timeout_ticks = kcl_pkg::TIMEOUT_RESET;
      countdown     = '0;
      entering      = 1'b0;
      code_enrolled = 1'b0;
      key_count     = 0;
      error_count   = 0;
    endfunction

    function void set_timeout(input logic [kcl_pkg::TIMEOUT_W-1:0] ticks);
      timeout_ticks = ticks;
    endfunction

    // Advance the lock state by one request and return its verdict
    function logic [kcl_pkg::VERDICT_W-1:0] predict_verdict(
        input logic [kcl_pkg::REQ_W-1:0] req,
        input logic [kcl_pkg::KEY_W-1:0] key);
      logic [kcl_pkg::VERDICT_W-1:0] verdict;
      verdict = kcl_pkg::VERDICT_NOTHING;
      case (req)
        kcl_pkg::REQ_KEY: begin
          if (!entering) begin
            entering  = 1'b1;
            key_count = 0;
          end
          countdown = timeout_ticks;
          if (key_count < kcl_pkg::CODE_LEN) entry_keys[key_count] = key;
          key_count++;
          if (key_count >= kcl_pkg::CODE_LEN) begin
            entering  = 1'b0;
            key_count = 0;
            if (!code_enrolled) begin
              stored_keys   = entry_keys;
              code_enrolled = 1'b1;
              verdict       = kcl_pkg::VERDICT_CHANGED;
            end else if (stored_keys == entry_keys) begin
              verdict = kcl_pkg::VERDICT_SUCCESS;
            end else begin
              verdict = kcl_pkg::VERDICT_WRONG;
            end
          end
        end
        kcl_pkg::REQ_TICK: begin
          if (entering) begin
            if (countdown == '0) begin
              entering  = 1'b0;
              key_count = 0;
              verdict   = kcl_pkg::VERDICT_WRONG;
            end else begin
              countdown = countdown - 1'b1;
            end
          end
        end
        kcl_pkg::REQ_FORGET: begin
          code_enrolled = 1'b0;
        end
        default: ;
      endcase
      return verdict;
    endfunction

    function void note_request(input logic [kcl_pkg::REQ_W-1:0] req,
                               input logic [kcl_pkg::KEY_W-1:0] key);
      expected_verdicts.push_back(predict_verdict(req, key));
    endfunction

    function void check_verdict(input logic [kcl_pkg::VERDICT_W-1:0] actual);
      logic [kcl_pkg::VERDICT_W-1:0] expected;
      if (expected_verdicts.size() == 0) begin
        $display("%0t: unexpected verdict transfer: expected none, actual %0d",
                 $time, actual);
        error_count++;
      end else begin
        expected = expected_verdicts.pop_front();
        if (actual !== expected) begin
          $display("%0t: verdict mismatch: expected %0d, actual %0d",
                   $time, expected, actual);
          error_count++;
        end
      end
    endfunction

    function int unsigned pending();
      return expected_verdicts.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block ports
  // --------------------------------------------------------------------------
  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_ready_o;
  logic [kcl_pkg::REQ_W-1:0]     req_type_i  = kcl_pkg::REQ_KEY;
  logic [kcl_pkg::KEY_W-1:0]     key_code_i  = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic [kcl_pkg::VERDICT_W-1:0] verdict_o;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [kcl_pkg::TIMEOUT_W-1:0] cfg_data_i  = '0;

  lock_scoreboard lock_sb = new();

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned calm_left     = 0;
  int unsigned counted_items = 0;

  always #1 clk_i = ~clk_i;

  keypad_code_lock i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .key_code_i  (key_code_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .verdict_o   (verdict_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // Check each verdict transfer and stall the output channel at random
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) lock_sb.check_verdict(verdict_o);
    out_ready_i <= (calm_left != 0) || ($urandom_range(99) >= recv_idle_pct);
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // Send one request, holding it until the transfer happens
  task automatic send_item(input logic [kcl_pkg::REQ_W-1:0] req,
                           input logic [kcl_pkg::KEY_W-1:0] key);
    if (calm_left != 0) begin
      calm_left--;
    end else if ($urandom_range(24) == 0) begin
      calm_left = $urandom_range(30, 8);
    end
    while ((calm_left == 0) && ($urandom_range(99) < send_idle_pct)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    key_code_i <= key;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    lock_sb.note_request(req, key);
    counted_items++;
  endtask

  // Hold off the sender until every verdict is back and the scan has settled
  task automatic drain_verdicts();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (lock_sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_timeout(input logic [kcl_pkg::TIMEOUT_W-1:0] ticks);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= ticks;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    lock_sb.set_timeout(ticks);
    cfg_valid_i <= 1'b0;
  endtask

  // Full code entries mixed with partial entries, forget requests, ticks and noise
  task automatic run_phase(input int unsigned target);
    logic [kcl_pkg::KEY_W-1:0] keys [kcl_pkg::CODE_LEN];
    int unsigned               action;
    int unsigned               num;
    int unsigned               gap;
    counted_items = 0;
    while (counted_items < target) begin
      action = $urandom_range(99);
      if ($urandom_range(49) == 0) drain_verdicts();
      if (action < 45) begin
        // full entry: the stored code, a near miss, or random keys
        num = $urandom_range(99);
        for (int i = 0; i < kcl_pkg::CODE_LEN; i++) begin
          keys[i] = 8'($urandom_range(255));
        end
        if (lock_sb.code_enrolled && num < 80) begin
          keys = lock_sb.stored_keys;
          if (num >= 55) begin
            keys[$urandom_range(kcl_pkg::CODE_LEN-1)] ^= 8'(1 << $urandom_range(7));
          end
        end
        for (int i = 0; i < kcl_pkg::CODE_LEN; i++) begin
          send_item(kcl_pkg::REQ_KEY, keys[i]);
          if ((i < kcl_pkg::CODE_LEN-1) && ($urandom_range(4) == 0)) begin
            gap = (lock_sb.timeout_ticks < 2) ? lock_sb.timeout_ticks : 2;
            repeat ($urandom_range(gap)) begin
              send_item(kcl_pkg::REQ_TICK, 8'($urandom_range(255)));
            end
          end
          if ((i < kcl_pkg::CODE_LEN-1) && ($urandom_range(19) == 0)) begin
            send_item(kcl_pkg::REQ_FORGET, 8'($urandom_range(255)));
          end
        end
      end else if (action < 62) begin
        // partial entry left to time out where the timeout is short
        repeat ($urandom_range(kcl_pkg::CODE_LEN-1, 1)) begin
          send_item(kcl_pkg::REQ_KEY, 8'($urandom_range(255)));
        end
        if (lock_sb.timeout_ticks <= 20) begin
          repeat (int'(lock_sb.timeout_ticks) + 1) begin
            send_item(kcl_pkg::REQ_TICK, 8'($urandom_range(255)));
          end
        end else begin
          repeat ($urandom_range(4, 1)) begin
            send_item(kcl_pkg::REQ_TICK, 8'($urandom_range(255)));
          end
        end
      end else if (action < 72) begin
        send_item(kcl_pkg::REQ_FORGET, 8'($urandom_range(255)));
      end else if (action < 82) begin
        repeat ($urandom_range(3, 1)) send_item(kcl_pkg::REQ_TICK, 8'($urandom_range(255)));
      end else if (action < 87) begin
        send_item(REQ_UNUSED, 8'($urandom_range(255)));
      end else begin
        send_item(2'($urandom_range(3)), 8'($urandom_range(255)));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [kcl_pkg::TIMEOUT_W-1:0] phase_timeouts [NUM_PHASES];
    phase_timeouts = '{16'd0, 16'd1, 16'd3, 16'hFFFF, 16'd7, 16'd2};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct = 18;
    recv_idle_pct = 57;

    // Directed: idle tick, ignored request, forget with no code
    send_item(kcl_pkg::REQ_TICK, 8'h00);
    send_item(REQ_UNUSED, 8'hFF);
    send_item(kcl_pkg::REQ_FORGET, 8'h00);
    // Enroll, then match, then miss by one bit in the last key
    send_item(kcl_pkg::REQ_KEY, 8'h00);
    send_item(kcl_pkg::REQ_KEY, 8'hFF);
    send_item(kcl_pkg::REQ_KEY, 8'h5A);
    send_item(kcl_pkg::REQ_KEY, 8'hA5);
    send_item(kcl_pkg::REQ_KEY, 8'h00);
    send_item(kcl_pkg::REQ_KEY, 8'hFF);
    send_item(kcl_pkg::REQ_KEY, 8'h5A);
    send_item(kcl_pkg::REQ_KEY, 8'hA5);
    send_item(kcl_pkg::REQ_KEY, 8'h00);
    send_item(kcl_pkg::REQ_KEY, 8'hFF);
    send_item(kcl_pkg::REQ_KEY, 8'h5A);
    send_item(kcl_pkg::REQ_KEY, 8'hA4);
    // Forget during an entry: the finished entry becomes the new code
    send_item(kcl_pkg::REQ_KEY, 8'h81);
    send_item(kcl_pkg::REQ_TICK, 8'h7E);
    send_item(kcl_pkg::REQ_FORGET, 8'h3C);
    send_item(kcl_pkg::REQ_KEY, 8'h42);
    send_item(kcl_pkg::REQ_KEY, 8'h18);
    send_item(kcl_pkg::REQ_KEY, 8'hE7);
    drain_verdicts();

    // Random phases over several timeout settings and idle mixes
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < 2) begin
        send_idle_pct = 18;
        recv_idle_pct = 57;
      end else if (p < 4) begin
        send_idle_pct = 57;
        recv_idle_pct = 18;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_timeout(phase_timeouts[p]);
      run_phase(PHASE_ITEMS);
      drain_verdicts();
    end

    if ((lock_sb.error_count == 0) && (lock_sb.pending() == 0)) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
